@@ rtl/tcc_pkg.sv @@
// Shared types and constants for the teletype cursor controller.
package tcc_pkg;

  localparam logic [7:0] CHAR_BELL      = 8'd7;
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_LF        = 8'd10;
  localparam logic [7:0] CHAR_CR        = 8'd13;
  localparam logic [7:0] CHAR_SPACE     = 8'd32;
  localparam logic [7:0] BELL_ATTR      = 8'd7;

  localparam logic [1:0] CFG_NUM_COLS  = 2'd0;
  localparam logic [1:0] CFG_NUM_ROWS  = 2'd1;
  localparam logic [1:0] CFG_TEXT_MODE = 2'd2;

  typedef struct packed {
    logic [7:0] num_cols;
    logic [7:0] num_rows;
    logic       text_mode;
  } tcc_cfg_t;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
  } tcc_cursor_t;

  typedef struct packed {
    logic [7:0] character;
    logic [7:0] attribute;
    logic       use_attribute;
    logic [7:0] cell_attribute;
  } tcc_item_t;

  typedef struct packed {
    logic       write_valid;
    logic [7:0] write_row;
    logic [7:0] write_col;
    logic [7:0] write_code;
    logic [7:0] write_attribute;
    logic       write_uses_attribute;
    logic       beep;
    logic       scroll;
    logic [7:0] fill_attribute;
    logic       cursor_valid;
    logic [7:0] cursor_row;
    logic [7:0] cursor_col;
  } tcc_result_t;

endpackage

@@ rtl/tcc_if.sv @@
// Handshake channel interfaces: character input, result output, config writes.
interface tcc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic [7:0] attribute;
  logic       use_attribute;
  logic [2:0] page;
  logic [7:0] cell_attribute;

  modport source (output valid, character, attribute, use_attribute, page, cell_attribute,
                  input ready);
  modport sink   (input valid, character, attribute, use_attribute, page, cell_attribute,
                  output ready);
endinterface

interface tcc_res_if;
  logic       valid;
  logic       ready;
  logic       write_valid;
  logic [7:0] write_row;
  logic [7:0] write_col;
  logic [7:0] write_code;
  logic [7:0] write_attribute;
  logic       write_uses_attribute;
  logic       beep;
  logic       scroll;
  logic [7:0] fill_attribute;
  logic       cursor_valid;
  logic [7:0] cursor_row;
  logic [7:0] cursor_col;

  modport source (output valid, write_valid, write_row, write_col, write_code,
                  write_attribute, write_uses_attribute, beep, scroll, fill_attribute,
                  cursor_valid, cursor_row, cursor_col,
                  input ready);
  modport sink   (input valid, write_valid, write_row, write_col, write_code,
                  write_attribute, write_uses_attribute, beep, scroll, fill_attribute,
                  cursor_valid, cursor_row, cursor_col,
                  output ready);
endinterface

interface tcc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [7:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ rtl/tcc_step.sv @@
// Cursor update for one character: write request, beep, scroll and new cursor.
module tcc_step
  import tcc_pkg::*;
(
  input  tcc_cfg_t    cfg_i,
  input  tcc_item_t   item_i,
  input  tcc_cursor_t cur_i,
  output tcc_result_t res_o,
  output tcc_cursor_t next_o
);

  always_comb begin
    logic [7:0] row;
    logic [7:0] col;
    logic       wr;
    logic       silent;
    logic [7:0] code;

    row    = cur_i.row;
    col    = cur_i.col;
    wr     = 1'b0;
    silent = 1'b0;
    code   = item_i.character;
    res_o  = '0;

    case (item_i.character)
      CHAR_BACKSPACE: begin
        if (col != 8'd0) col = col - 8'd1;
      end
      CHAR_CR: begin
        col = 8'd0;
      end
      CHAR_LF: begin
        row = row + 8'd1;
      end
      default: begin
        if (item_i.character == CHAR_BELL) begin
          res_o.beep = 1'b1;
          code       = CHAR_SPACE;
          // text-mode bell on a cell not holding attribute 7 only beeps
          if (cfg_i.text_mode && item_i.cell_attribute != BELL_ATTR) silent = 1'b1;
        end
        if (!silent) begin
          wr                         = 1'b1;
          res_o.write_valid          = 1'b1;
          res_o.write_row            = row;
          res_o.write_col            = col;
          res_o.write_code           = code;
          res_o.write_attribute      = item_i.attribute;
          res_o.write_uses_attribute = item_i.use_attribute;
          col                        = col + 8'd1;
        end
      end
    endcase

    if (!silent) begin
      if (col == cfg_i.num_cols) begin
        col = 8'd0;
        row = row + 8'd1;
      end
      if (row == cfg_i.num_rows) begin
        res_o.scroll = 1'b1;
        if (cfg_i.text_mode) begin
          res_o.fill_attribute = (wr && item_i.use_attribute) ? item_i.attribute
                                                              : item_i.cell_attribute;
        end
        row = row - 8'd1;
      end
      res_o.cursor_valid = 1'b1;
      res_o.cursor_row   = row;
      res_o.cursor_col   = col;
    end

    next_o.row = row;
    next_o.col = col;
  end

endmodule

@@ rtl/teletype_cursor_controller.sv @@
// Teletype cursor controller top level: per-page cursor memory and result pipeline.
// Takes one character per clock cycle, back to back, on any mix of pages, as long as
// the result output is not stalled; a character is registered in stage 1 and its result
// in the output register. Each page's row and column live in a small synchronous memory
// with one read and one write port: the read is issued when a character is accepted, the
// update is computed in the following cycle and written back as the result moves into
// the output register, and a character for the same page right behind it takes the
// fresh cursor from a forwarding path. Entries that have never been written read as
// row 0, column 0; no clearing pass is needed after reset. Configuration writes are
// accepted in every cycle and should be made only while no character is in flight.
module teletype_cursor_controller
  import tcc_pkg::*;
#(
  parameter int PAGE_COUNT = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcc_char_if.sink  char_i,
  tcc_res_if.source res_o,
  tcc_cfg_if.sink   cfg_i
);

  localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam logic [3:0] PageCnt = 4'(PAGE_COUNT);

  // configuration
  tcc_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_cols  <= 8'd80;
      cfg_q.num_rows  <= 8'd25;
      cfg_q.text_mode <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        CFG_NUM_COLS:  cfg_q.num_cols  <= cfg_i.wdata;
        CFG_NUM_ROWS:  cfg_q.num_rows  <= cfg_i.wdata;
        CFG_TEXT_MODE: cfg_q.text_mode <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  // page index, folded into the page count
  logic [3:0]    pg_mod;
  logic [PW-1:0] in_idx;

  always_comb begin
    pg_mod = {1'b0, char_i.page};
    for (int k = 0; k < 8; k++) begin
      if (pg_mod >= PageCnt) pg_mod = pg_mod - PageCnt;
    end
    in_idx = pg_mod[PW-1:0];
  end

  // pipeline control
  logic        s1_v_q;
  tcc_item_t   s1_item_q;
  logic [PW-1:0] s1_idx_q;
  logic        out_v_q;
  tcc_result_t out_q;
  logic        s1_adv;
  logic        in_acc;
  logic        wr_en;

  tcc_cursor_t step_cur;
  tcc_cursor_t step_next;
  tcc_result_t step_res;

  assign s1_adv      = s1_v_q && (!out_v_q || res_o.ready);
  assign char_i.ready = !s1_v_q || s1_adv;
  assign in_acc      = char_i.valid && char_i.ready;
  assign wr_en       = s1_adv && step_res.cursor_valid;

  // cursor memory
  tcc_cursor_t mem [PAGE_COUNT];
  logic [PAGE_COUNT-1:0] ent_vld_q;
  tcc_cursor_t rd_q;
  logic        rd_vld_q;
  logic        fwd_q;
  tcc_cursor_t fwd_cur_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[s1_idx_q] <= step_next;
    if (in_acc) rd_q <= mem[in_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (wr_en) begin
      ent_vld_q[s1_idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_vld_q  <= ent_vld_q[in_idx];
      // write to the same page lands this edge: bypass the memory read
      fwd_q     <= wr_en && (s1_idx_q == in_idx);
      fwd_cur_q <= step_next;
      s1_item_q.character      <= char_i.character;
      s1_item_q.attribute      <= char_i.attribute;
      s1_item_q.use_attribute  <= char_i.use_attribute;
      s1_item_q.cell_attribute <= char_i.cell_attribute;
      s1_idx_q  <= in_idx;
    end
  end

  always_comb begin
    if (fwd_q) step_cur = fwd_cur_q;
    else if (rd_vld_q) step_cur = rd_q;
    else step_cur = '0;
  end

  tcc_step u_step (
    .cfg_i  (cfg_q),
    .item_i (s1_item_q),
    .cur_i  (step_cur),
    .res_o  (step_res),
    .next_o (step_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_acc) s1_v_q <= 1'b1;
      else if (s1_adv) s1_v_q <= 1'b0;
      if (s1_adv) out_v_q <= 1'b1;
      else if (res_o.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) out_q <= step_res;
  end

  assign res_o.valid                = out_v_q;
  assign res_o.write_valid          = out_q.write_valid;
  assign res_o.write_row            = out_q.write_row;
  assign res_o.write_col            = out_q.write_col;
  assign res_o.write_code           = out_q.write_code;
  assign res_o.write_attribute      = out_q.write_attribute;
  assign res_o.write_uses_attribute = out_q.write_uses_attribute;
  assign res_o.beep                 = out_q.beep;
  assign res_o.scroll               = out_q.scroll;
  assign res_o.fill_attribute       = out_q.fill_attribute;
  assign res_o.cursor_valid         = out_q.cursor_valid;
  assign res_o.cursor_row           = out_q.cursor_row;
  assign res_o.cursor_col           = out_q.cursor_col;

  // checks
  a_acc_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_v_q)
    else $error("accepted transaction did not reach stage 1");

  a_stall_holds_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !s1_adv |=> s1_v_q && $stable(s1_idx_q))
    else $error("stalled stage 1 lost its transaction");

  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> ent_vld_q[$past(s1_idx_q)])
    else $error("cursor write did not mark its entry valid");

  a_fwd_same_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && wr_en && (s1_idx_q == in_idx) |=> fwd_q && (fwd_cur_q == $past(step_next)))
    else $error("missed cursor forward for back-to-back same page");

  a_silent_bell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_q.cursor_valid |-> out_q.beep && !out_q.write_valid && !out_q.scroll)
    else $error("result without cursor update is not a silent bell");

endmodule

@@ tb/tb_teletype_cursor_controller.sv @@
// Self-checking testbench for the teletype cursor controller: directed table, then random phases.
module tb_teletype_cursor_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;

  localparam int PAGES       = 8;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [7:0] character;
    logic [7:0] attribute;
    logic       use_attribute;
    logic [2:0] page;
    logic [7:0] cell_attribute;
  } char_txn_t;

  typedef struct packed {
    logic        known;
    tcc_result_t value;
  } typed_result_t;

  typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e     kind;
    logic [1:0]    reg_index;
    logic [7:0]    wdata;
    char_txn_t     txn;
    typed_result_t typed;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  tcc_char_if char_if ();
  tcc_res_if  res_if ();
  tcc_cfg_if  cfg_if ();

  teletype_cursor_controller #(.PAGE_COUNT(PAGES)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Shadow state of the console engine
  tcc_cfg_t   screen_cfg;
  logic [7:0] cursor_row_mem [PAGES];
  logic [7:0] cursor_col_mem [PAGES];

  tcc_result_t   predicted_results_q [$];
  typed_result_t typed_results_q [$];
  stim_row_t     directed_rows [$];

  int error_count;
  int cycle_count;
  int stall_left;
  bit quiet;

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result-side back-pressure: mostly short stalls, now and then a long one
  always @(posedge clk_i) begin
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet) begin
      res_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (pick < 70) begin
      res_if.ready <= 1'b1;
    end else if (pick < 95) begin
      res_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 2);
    end else begin
      res_if.ready <= 1'b0;
      stall_left   <= $urandom_range(10, 50);
    end
  end

  function automatic tcc_result_t advance_cursor(input char_txn_t t);
    tcc_result_t r;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [7:0]  code;
    logic        wrote;
    r     = '0;
    row   = cursor_row_mem[t.page];
    col   = cursor_col_mem[t.page];
    code  = t.character;
    wrote = 1'b0;
    case (t.character)
      CHAR_BACKSPACE: begin
        if (col != 8'd0) col = col - 8'd1;
      end
      CHAR_CR: begin
        col = 8'd0;
      end
      CHAR_LF: begin
        row = row + 8'd1;
      end
      default: begin
        if (t.character == CHAR_BELL) begin
          r.beep = 1'b1;
          // text-mode bell on a cell not holding the bell attribute only beeps
          if (screen_cfg.text_mode && t.cell_attribute != BELL_ATTR) return r;
          code = CHAR_SPACE;
        end
        wrote                  = 1'b1;
        r.write_valid          = 1'b1;
        r.write_row            = row;
        r.write_col            = col;
        r.write_code           = code;
        r.write_attribute      = t.attribute;
        r.write_uses_attribute = t.use_attribute;
        col                    = col + 8'd1;
      end
    endcase
    if (col == screen_cfg.num_cols) begin
      col = 8'd0;
      row = row + 8'd1;
    end
    if (row == screen_cfg.num_rows) begin
      r.scroll = 1'b1;
      if (screen_cfg.text_mode)
        r.fill_attribute = (wrote && t.use_attribute) ? t.attribute : t.cell_attribute;
      row = row - 8'd1;
    end
    cursor_row_mem[t.page] = row;
    cursor_col_mem[t.page] = col;
    r.cursor_valid = 1'b1;
    r.cursor_row   = row;
    r.cursor_col   = col;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (error_count < 40)
      $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_field(input string what, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_result(input tcc_result_t got, input tcc_result_t want);
    check_field("write_valid", 8'(got.write_valid), 8'(want.write_valid));
    check_field("write_row", got.write_row, want.write_row);
    check_field("write_col", got.write_col, want.write_col);
    check_field("write_code", got.write_code, want.write_code);
    check_field("write_attribute", got.write_attribute, want.write_attribute);
    check_field("write_uses_attribute", 8'(got.write_uses_attribute),
                8'(want.write_uses_attribute));
    check_field("beep", 8'(got.beep), 8'(want.beep));
    check_field("scroll", 8'(got.scroll), 8'(want.scroll));
    check_field("fill_attribute", got.fill_attribute, want.fill_attribute);
    check_field("cursor_valid", 8'(got.cursor_valid), 8'(want.cursor_valid));
    check_field("cursor_row", got.cursor_row, want.cursor_row);
    check_field("cursor_col", got.cursor_col, want.cursor_col);
  endtask

  // Single process for config, input and output transactions keeps ordering fixed
  always @(posedge clk_i) begin : scoreboard
    char_txn_t     t;
    tcc_result_t   got;
    tcc_result_t   want;
    typed_result_t lit;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.reg_index)
          CFG_NUM_COLS:  screen_cfg.num_cols  = cfg_if.wdata;
          CFG_NUM_ROWS:  screen_cfg.num_rows  = cfg_if.wdata;
          CFG_TEXT_MODE: screen_cfg.text_mode = cfg_if.wdata[0];
          default: ;
        endcase
      end
      if (char_if.valid && char_if.ready) begin
        t.character      = char_if.character;
        t.attribute      = char_if.attribute;
        t.use_attribute  = char_if.use_attribute;
        t.page           = char_if.page;
        t.cell_attribute = char_if.cell_attribute;
        want = advance_cursor(t);
        lit  = typed_results_q.pop_front();
        if (lit.known) want = lit.value;
        predicted_results_q.push_back(want);
      end
      if (res_if.valid && res_if.ready) begin
        got = {res_if.write_valid, res_if.write_row, res_if.write_col, res_if.write_code,
               res_if.write_attribute, res_if.write_uses_attribute, res_if.beep,
               res_if.scroll, res_if.fill_attribute, res_if.cursor_valid,
               res_if.cursor_row, res_if.cursor_col};
        if (predicted_results_q.size() == 0) report_mismatch("unexpected result", 8'd0, 8'd0);
        else check_result(got, predicted_results_q.pop_front());
      end
    end
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_char(input char_txn_t t, input typed_result_t typed, input int gap);
    if (gap > 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    typed_results_q.push_back(typed);
    char_if.valid          <= 1'b1;
    char_if.character      <= t.character;
    char_if.attribute      <= t.attribute;
    char_if.use_attribute  <= t.use_attribute;
    char_if.page           <= t.page;
    char_if.cell_attribute <= t.cell_attribute;
    do @(posedge clk_i); while (!char_if.ready);
  endtask

  task automatic wait_drained();
    char_if.valid <= 1'b0;
    @(posedge clk_i);
    while (predicted_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] cols, input logic [7:0] rows,
                           input logic text, input int count, input int page_sel,
                           input int special_pct, input bit quiet_phase);
    char_txn_t t;
    int        pick;
    wait_drained();
    write_reg(CFG_NUM_COLS, cols);
    write_reg(CFG_NUM_ROWS, rows);
    write_reg(CFG_TEXT_MODE, {7'd0, text});
    quiet = quiet_phase;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < special_pct) begin
        case ($urandom_range(0, 3))
          0:       t.character = CHAR_BACKSPACE;
          1:       t.character = CHAR_CR;
          2:       t.character = CHAR_LF;
          default: t.character = CHAR_BELL;
        endcase
      end else begin
        t.character = 8'($urandom_range(0, 255));
      end
      t.attribute      = 8'($urandom_range(0, 255));
      t.use_attribute  = 1'($urandom_range(0, 1));
      t.page           = (page_sel < 0) ? 3'($urandom_range(0, PAGES - 1)) : 3'(page_sel);
      t.cell_attribute = 8'($urandom_range(0, 255));
      if (t.character == CHAR_BELL && $urandom_range(0, 1)) t.cell_attribute = BELL_ATTR;
      // occasional full drain with the sender held off
      if (!quiet && $urandom_range(0, 249) == 0) wait_drained();
      send_char(t, '0, pick_gap());
    end
    quiet = 1'b0;
  endtask

  function automatic stim_row_t char_row(input char_txn_t t, input bit known,
                                         input tcc_result_t value);
    stim_row_t r;
    r.kind        = ROW_CHAR;
    r.reg_index   = CFG_NUM_COLS;
    r.wdata       = 8'd0;
    r.txn         = t;
    r.typed.known = known;
    r.typed.value = value;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [7:0] data);
    stim_row_t r;
    r           = char_row('0, 1'b0, '0);
    r.kind      = ROW_CFG;
    r.reg_index = idx;
    r.wdata     = data;
    return r;
  endfunction

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    quiet       = 1'b0;
    stall_left  = 0;
    error_count = 0;
    cycle_count = 0;
    char_if.valid          = 1'b0;
    char_if.character      = 8'd0;
    char_if.attribute      = 8'd0;
    char_if.use_attribute  = 1'b0;
    char_if.page           = 3'd0;
    char_if.cell_attribute = 8'd0;
    cfg_if.valid           = 1'b0;
    cfg_if.reg_index       = CFG_NUM_COLS;
    cfg_if.wdata           = 8'd0;
    res_if.ready           = 1'b0;
    screen_cfg = '{num_cols: 8'd80, num_rows: 8'd25, text_mode: 1'b1};
    for (int p = 0; p < PAGES; p++) begin
      cursor_row_mem[p] = 8'd0;
      cursor_col_mem[p] = 8'd0;
    end

    // Input: {char, attr, use_attr, page, cell_attr}
    // Result: {wv, wrow, wcol, code, wattr, wua, beep, scroll, fill, cv, crow, ccol}
    directed_rows.push_back(char_row({8'd65, 8'h1F, 1'b1, 3'd0, 8'h07}, 1'b1,
      {1'b1, 8'd0, 8'd0, 8'd65, 8'h1F, 1'b1, 1'b0, 1'b0, 8'd0, 1'b1, 8'd0, 8'd1}));
    directed_rows.push_back(char_row({8'hFF, 8'hFF, 1'b0, 3'd7, 8'hFF}, 1'b1,
      {1'b1, 8'd0, 8'd0, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1, 8'd0, 8'd1}));
    directed_rows.push_back(char_row({8'd0, 8'd0, 1'b1, 3'd3, 8'd0}, 1'b1,
      {1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0, 8'd0, 1'b1, 8'd0, 8'd1}));
    // backspace held at column 0, then stepping back from column 1 to 0
    directed_rows.push_back(char_row({CHAR_BACKSPACE, 8'hAA, 1'b1, 3'd1, 8'h55}, 1'b1,
      {1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1, 8'd0, 8'd0}));
    directed_rows.push_back(char_row({CHAR_BACKSPACE, 8'h00, 1'b0, 3'd0, 8'h00}, 1'b1,
      {1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1, 8'd0, 8'd0}));
    // silent bell: beep only
    directed_rows.push_back(char_row({CHAR_BELL, 8'h12, 1'b1, 3'd2, 8'h70}, 1'b1,
      {1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0, 8'd0, 8'd0}));
    directed_rows.push_back(char_row({CHAR_BELL, 8'h4E, 1'b1, 3'd2, BELL_ATTR}, 1'b1,
      {1'b1, 8'd0, 8'd0, CHAR_SPACE, 8'h4E, 1'b1, 1'b1, 1'b0, 8'd0, 1'b1, 8'd0, 8'd1}));
    directed_rows.push_back(char_row({CHAR_LF, 8'h00, 1'b0, 3'd2, 8'h00}, 1'b1,
      {1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1, 8'd1, 8'd1}));
    directed_rows.push_back(char_row({CHAR_CR, 8'h00, 1'b0, 3'd2, 8'h00}, 1'b1,
      {1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b1, 8'd1, 8'd0}));
    directed_rows.push_back(cfg_row(CFG_TEXT_MODE, 8'd0));
    // graphics bell always writes a space
    directed_rows.push_back(char_row({CHAR_BELL, 8'h0F, 1'b0, 3'd4, 8'h33}, 1'b1,
      {1'b1, 8'd0, 8'd0, CHAR_SPACE, 8'h0F, 1'b0, 1'b1, 1'b0, 8'd0, 1'b1, 8'd0, 8'd1}));
    directed_rows.push_back(cfg_row(CFG_NUM_COLS, 8'd1));
    directed_rows.push_back(cfg_row(CFG_NUM_ROWS, 8'd1));
    // wrap plus scroll, graphics fill is 0
    directed_rows.push_back(char_row({8'd120, 8'h2A, 1'b1, 3'd5, 8'h13}, 1'b1,
      {1'b1, 8'd0, 8'd0, 8'd120, 8'h2A, 1'b1, 1'b0, 1'b1, 8'd0, 1'b1, 8'd0, 8'd0}));
    directed_rows.push_back(cfg_row(CFG_TEXT_MODE, 8'd1));
    directed_rows.push_back(char_row({8'd121, 8'h2A, 1'b1, 3'd5, 8'h13}, 1'b1,
      {1'b1, 8'd0, 8'd0, 8'd121, 8'h2A, 1'b1, 1'b0, 1'b1, 8'h2A, 1'b1, 8'd0, 8'd0}));
    directed_rows.push_back(char_row({8'd122, 8'h2A, 1'b0, 3'd5, 8'h13}, 1'b1,
      {1'b1, 8'd0, 8'd0, 8'd122, 8'h2A, 1'b0, 1'b0, 1'b1, 8'h13, 1'b1, 8'd0, 8'd0}));
    directed_rows.push_back(char_row({CHAR_LF, 8'h2A, 1'b1, 3'd5, 8'h55}, 1'b1,
      {1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1, 8'h55, 1'b1, 8'd0, 8'd0}));
    directed_rows.push_back(char_row({CHAR_BELL, 8'h66, 1'b1, 3'd5, BELL_ATTR}, 1'b1,
      {1'b1, 8'd0, 8'd0, CHAR_SPACE, 8'h66, 1'b1, 1'b1, 1'b1, 8'h66, 1'b1, 8'd0, 8'd0}));
    // zero screen sizes
    directed_rows.push_back(cfg_row(CFG_NUM_COLS, 8'd0));
    directed_rows.push_back(cfg_row(CFG_NUM_ROWS, 8'd0));
    directed_rows.push_back(char_row({8'd113, 8'h01, 1'b0, 3'd6, 8'h44}, 1'b1,
      {1'b1, 8'd0, 8'd0, 8'd113, 8'h01, 1'b0, 1'b0, 1'b1, 8'h44, 1'b1, 8'hFF, 8'd1}));
    directed_rows.push_back(char_row({CHAR_LF, 8'h00, 1'b0, 3'd6, 8'h9C}, 1'b1,
      {1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1, 8'h9C, 1'b1, 8'hFF, 8'd1}));
    directed_rows.push_back(char_row({CHAR_BACKSPACE, 8'h00, 1'b0, 3'd6, 8'h21}, 1'b0, '0));
    directed_rows.push_back(cfg_row(CFG_NUM_COLS, 8'd255));
    directed_rows.push_back(cfg_row(CFG_NUM_ROWS, 8'd255));
    directed_rows.push_back(char_row({CHAR_LF, 8'h00, 1'b1, 3'd6, 8'h00}, 1'b0, '0));
    directed_rows.push_back(char_row({8'd65, 8'hC3, 1'b1, 3'd6, 8'h3C}, 1'b0, '0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(directed_rows[i].reg_index, directed_rows[i].wdata);
      end else begin
        send_char(directed_rows[i].txn, directed_rows[i].typed, pick_gap());
      end
    end

    run_phase(8'd80, 8'd25, 1'b1, 200, -1, 30, 1'b0);
    run_phase(8'd1, 8'd1, 1'b0, 150, -1, 30, 1'b0);
    run_phase(8'd255, 8'd255, 1'b1, 150, 3, 10, 1'b0);
    // cursor runs off the screen and wraps its 8-bit column
    run_phase(8'd0, 8'd0, 1'b1, 350, 6, 2, 1'b0);
    run_phase(8'($urandom_range(2, 10)), 8'($urandom_range(2, 6)), 1'($urandom_range(0, 1)),
              150, -1, 35, 1'b1);
    run_phase(8'($urandom_range(2, 10)), 8'($urandom_range(2, 6)), 1'($urandom_range(0, 1)),
              150, -1, 35, 1'b0);
    run_phase(8'($urandom_range(1, 20)), 8'($urandom_range(1, 8)), 1'($urandom_range(0, 1)),
              150, $urandom_range(0, PAGES - 1), 35, 1'b0);
    run_phase(8'd8, 8'd3, 1'b1, 150, -1, 40, 1'b0);
    run_phase(8'd5, 8'd255, 1'b0, 150, -1, 25, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
